// ----- hdl/tfc_pkg.sv -----
`default_nettype none

package tfc_pkg;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] REQ_CAPTURE  = 2'd0;
  localparam logic [1:0] REQ_OVERFLOW = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOCK_HZ  = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_HOLDOFF   = 2'd2;

  // Field widths.
  localparam int CAP_W  = 16;
  localparam int FREQ_W = 32;
  localparam int SUM_W  = 36;
  localparam int THR_W  = 26;
  localparam int HOLD_W = 16;
  localparam int CNT_W  = $clog2(FREQ_W + 1);

  // Register values after reset.
  localparam logic [FREQ_W-1:0] CLOCK_HZ_RST  = 32'd64000000;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 26'd20000;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST   = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_TOUCH,
    ST_FINISH
  } st_t;

  // Status of the serial divider, seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hdl/touch_frequency_counter_unit.sv -----
`default_nettype none

// Channel   Dir  Beat fields (lowest bit first)
// --------  ---  --------------------------------------------------------------
// s_*       in   tuser: req_type[1:0]; tdata: capture_value[15:0]
// m_*       out  tuser: freq_valid; tdata: measured_freq[31:0],
//                window_sum[67:32], touch_state[68], zero fill [71:69]
// cfg_*     in   cfg_index[1:0] selects clock_hz, touch_threshold_hz, holdoff_ms
//
// Overflow, tick, start-edge, ignored and zero-period beats go from idle
// straight to the finish state, which loads the output register once it is
// free. An end edge with a nonzero period runs the serial divider, then a
// read, update and touch-check pass over the window memory (skipped for a
// zero quotient) before finish. The next beat is taken once back in idle.
// Reset is synchronous and clears the control state and the window valid
// bits, so the window reads as all zeros without a clearing pass. Both ready
// lines stay low while reset is high.
// One beat is processed at a time. A new beat is taken while the previous
// result still waits in the output register; a stalled output holds the
// finished item until the register frees up.
module touch_frequency_counter_unit #(
  parameter int WINDOW = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input events.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // capture_value[15:0]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  // Results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [71:0] m_tdata,   // measured_freq, window_sum, touch_state
  output logic             m_tuser,   // freq_valid
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import tfc_pkg::*;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Configuration registers.
  logic [FREQ_W-1:0] clock_hz;
  logic [THR_W-1:0]  touch_threshold_hz;
  logic [HOLD_W-1:0] holdoff_ms;

  // Measurement and detector state.
  logic              waiting_end_edge;
  logic [CAP_W-1:0]  start_capture;
  logic [CAP_W-1:0]  overflow_count;
  logic [PTR_W-1:0]  window_pointer;
  logic [SUM_W-1:0]  running_sum;
  logic [HOLD_W-1:0] holdoff_count;
  logic              touch_flag;
  logic              sample_valid;

  // The sample window lives in a small synchronous memory. Entries that have
  // never been written read as zero through their valid bit.
  logic [FREQ_W-1:0] window_mem [WINDOW];
  logic [WINDOW-1:0] win_valid;
  logic [FREQ_W-1:0] rd_data;
  logic              rd_valid;

  // Output register.
  logic              out_freq_valid;
  logic [FREQ_W-1:0] out_freq;
  logic [SUM_W-1:0]  out_sum;
  logic              out_touch;

  st_t               state;
  st_t               state_next;

  logic              accept;
  logic              out_free;
  logic [FREQ_W-1:0] period;
  logic              div_start;
  logic [FREQ_W-1:0] div_q;
  div_stat_t         div_stat;
  logic [FREQ_W-1:0] old_sample;
  logic [SUM_W-1:0]  threshold_sum;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = !rst;

  // Period over the run: end + 65536 * overflows - start, wrapping at 32 bits.
  assign period = {overflow_count, s_tdata} - {{(FREQ_W-CAP_W){1'b0}}, start_capture};

  assign div_start = accept && (s_tuser == REQ_CAPTURE) && waiting_end_edge
                     && (period != '0);

  tfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_hz),
    .divisor  (period),
    .quotient (div_q),
    .stat     (div_stat)
  );

  assign old_sample    = rd_valid ? rd_data : '0;
  // Comparing the sum with threshold times the window length is the exact
  // form of comparing the average with the threshold.
  assign threshold_sum = SUM_W'(touch_threshold_hz) * SUM_W'(WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (accept) begin
          state_next = div_start ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = (div_q != '0) ? ST_READ : ST_FINISH;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_TOUCH;
      ST_TOUCH:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz           <= CLOCK_HZ_RST;
      touch_threshold_hz <= THRESHOLD_RST;
      holdoff_ms         <= HOLDOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLOCK_HZ:  clock_hz           <= cfg_data;
        CFG_THRESHOLD: touch_threshold_hz <= cfg_data[THR_W-1:0];
        CFG_HOLDOFF:   holdoff_ms         <= cfg_data[HOLD_W-1:0];
        default:       ;
      endcase
    end
  end

  // Event handling and the window update.
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_end_edge <= 1'b0;
      start_capture    <= '0;
      overflow_count   <= '0;
      window_pointer   <= '0;
      running_sum      <= '0;
      holdoff_count    <= '0;
      touch_flag       <= 1'b0;
      sample_valid     <= 1'b0;
      win_valid        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sample_valid <= 1'b0;
            case (s_tuser)
              REQ_CAPTURE: begin
                if (!waiting_end_edge) begin
                  start_capture    <= s_tdata;
                  overflow_count   <= '0;
                  waiting_end_edge <= 1'b1;
                end else begin
                  waiting_end_edge <= 1'b0;
                end
              end
              REQ_OVERFLOW: overflow_count <= overflow_count + 1'b1;
              REQ_TICK: begin
                if (holdoff_count != '1) begin
                  holdoff_count <= holdoff_count + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done && (div_q != '0)) begin
            sample_valid <= 1'b1;
          end
        end
        ST_UPDATE: begin
          running_sum               <= running_sum + SUM_W'(div_q) - SUM_W'(old_sample);
          win_valid[window_pointer] <= 1'b1;
          if (window_pointer == PTR_W'(WINDOW - 1)) begin
            window_pointer <= '0;
          end else begin
            window_pointer <= window_pointer + 1'b1;
          end
        end
        ST_TOUCH: begin
          if ((running_sum < threshold_sum) && (holdoff_count > holdoff_ms)) begin
            touch_flag    <= !touch_flag;
            holdoff_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Window memory: one write port, one registered read port at the pointer.
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      window_mem[window_pointer] <= div_q;
    end
    rd_data  <= window_mem[window_pointer];
    rd_valid <= win_valid[window_pointer];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_freq_valid <= sample_valid;
      out_freq       <= sample_valid ? div_q : '0;
      out_sum        <= running_sum;
      out_touch      <= touch_flag;
    end
  end

  assign m_tuser = out_freq_valid;
  assign m_tdata = {3'b000, out_touch, out_sum, out_freq};

  // A reported sample is never zero.
  a_freq_nonzero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[31:0] != '0))
    else $error("reported sample has zero frequency");

  // The ring pointer stays inside the window.
  a_ptr_range : assert property (@(posedge clk) disable iff (rst)
    window_pointer <= PTR_W'(WINDOW - 1))
    else $error("window pointer outside the window");

  // While waiting on a quotient the divider is running or just finished.
  a_div_running : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  // An accepted beat always leaves the idle state.
  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted beat not processed");

endmodule

`default_nettype wire

// ----- hdl/tfc_div.sv -----
`default_nettype none

module tfc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tfc_pkg::FREQ_W-1:0] dividend,
  input  wire logic [tfc_pkg::FREQ_W-1:0] divisor,
  output logic      [tfc_pkg::FREQ_W-1:0] quotient,
  output tfc_pkg::div_stat_t              stat
);
  import tfc_pkg::*;

  // Restoring division, one quotient bit per cycle. The quotient register
  // shifts in result bits as the dividend bits shift out of its top.
  logic [FREQ_W-1:0] rem;
  logic [FREQ_W-1:0] dvsr;
  logic [CNT_W-1:0]  count;
  logic              done;
  logic [FREQ_W:0]   rem_sh;
  logic [FREQ_W:0]   trial;

  assign rem_sh = {rem, quotient[FREQ_W-1]};
  assign trial  = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(FREQ_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (count != '0) begin
      if (!trial[FREQ_W]) begin
        rem      <= trial[FREQ_W-1:0];
        quotient <= {quotient[FREQ_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[FREQ_W-1:0];
        quotient <= {quotient[FREQ_W-2:0], 1'b0};
      end
    end
  end

  // Packed as busy, done from the top bit down.
  assign stat = {(count != '0), done};

endmodule

`default_nettype wire

// ----- verif/touch_frequency_counter_checker.sv -----
`timescale 1ns / 1ps

// Watches the event, result and register channels of the touch frequency counter.
// It keeps its own copy of the counter state, works out the reading that each
// accepted event beat should produce, and compares it with the result beats in order.
module touch_frequency_counter_checker #(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          readings_owed
);

  import tfc_pkg::*;

  typedef struct {
    logic              fresh;
    logic [FREQ_W-1:0] freq;
    logic [SUM_W-1:0]  sum;
    logic              touch;
  } reading_t;

  logic [FREQ_W-1:0] clock_hz_q;
  logic [THR_W-1:0]  threshold_q;
  logic [HOLD_W-1:0] holdoff_q;

  logic              awaiting_end;
  logic [CAP_W-1:0]  start_edge;
  logic [15:0]       wrap_count;
  logic [FREQ_W-1:0] samples [WINDOW];
  int                slot;
  logic [SUM_W-1:0]  sample_sum;
  logic [15:0]       tick_count;
  logic              touch_q;

  reading_t readings_due [$];

  // Advances the model state by one event and returns the reading it yields.
  function automatic reading_t next_reading(input logic [1:0] kind,
                                            input logic [CAP_W-1:0] cap);
    logic [31:0]       period;
    logic [FREQ_W-1:0] quot;
    reading_t          r;
    r.fresh = 1'b0;
    r.freq  = '0;
    case (kind)
      REQ_CAPTURE: begin
        if (!awaiting_end) begin
          start_edge   = cap;
          wrap_count   = '0;
          awaiting_end = 1'b1;
        end else begin
          period = {wrap_count, 16'h0000} + 32'(cap) - 32'(start_edge);
          if (period != 0) begin
            quot = clock_hz_q / period;
            if (quot != 0) begin
              r.fresh = 1'b1;
              r.freq  = quot;
              sample_sum    = sample_sum + SUM_W'(quot) - SUM_W'(samples[slot]);
              samples[slot] = quot;
              slot          = (slot + 1 == WINDOW) ? 0 : slot + 1;
              if (sample_sum < SUM_W'(threshold_q) * SUM_W'(WINDOW) &&
                  tick_count > holdoff_q) begin
                touch_q    = ~touch_q;
                tick_count = '0;
              end
            end
          end
          awaiting_end = 1'b0;
        end
      end
      REQ_OVERFLOW: wrap_count = wrap_count + 1'b1;
      REQ_TICK: begin
        if (tick_count != 16'hFFFF) tick_count = tick_count + 1'b1;
      end
      default: ;
    endcase
    r.sum   = sample_sum;
    r.touch = touch_q;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      clock_hz_q   = CLOCK_HZ_RST;
      threshold_q  = THRESHOLD_RST;
      holdoff_q    = HOLDOFF_RST;
      awaiting_end = 1'b0;
      start_edge   = '0;
      wrap_count   = '0;
      foreach (samples[i]) samples[i] = '0;
      slot         = 0;
      sample_sum   = '0;
      tick_count   = '0;
      touch_q      = 1'b0;
      mismatches   = 0;
      readings_due.delete();
      readings_owed <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (readings_due.size() == 0) begin
          note_mismatch("unrequested result", '0, m_tdata[63:0]);
        end else begin
          want = readings_due.pop_front();
          if (m_tuser !== want.fresh) note_mismatch("freq_valid", want.fresh, m_tuser);
          if (m_tdata[31:0] !== want.freq)
            note_mismatch("measured_freq", want.freq, m_tdata[31:0]);
          if (m_tdata[67:32] !== want.sum)
            note_mismatch("window_sum", want.sum, m_tdata[67:32]);
          if (m_tdata[68] !== want.touch)
            note_mismatch("touch_state", want.touch, m_tdata[68]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLOCK_HZ:  clock_hz_q  = cfg_data;
          CFG_THRESHOLD: threshold_q = cfg_data[THR_W-1:0];
          CFG_HOLDOFF:   holdoff_q   = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) readings_due.push_back(next_reading(s_tuser, s_tdata));
      readings_owed <= readings_due.size();
    end
  end

endmodule

// ----- verif/touch_frequency_counter_unit_tb.sv -----
`timescale 1ns / 1ps

// The top drives event beats and register writes and decides the verdict. All
// prediction and comparison lives in the checker that sits beside the block.
module touch_frequency_counter_unit_tb;

  import tfc_pkg::*;

  localparam int WINDOW = 10;

  // Codes the package leaves unnamed: an unused request kind and a register
  // index past the end of the list. The block must ignore both.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int mismatches;
  int readings_owed;

  // Stimulus controls. The sender and the receiver each idle at random only
  // while their flag is set; long_hold asks the receiver for one long stall.
  bit tx_gaps;
  bit rx_stalls;
  bit long_hold;
  int beats_sent;
  // Tracks whether the next capture beat lands as an end edge.
  bit end_pending;

  touch_frequency_counter_unit #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  touch_frequency_counter_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .readings_owed(readings_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no pause, sometimes a few cycles, now and then a long one.
  function automatic int pause_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one event beat and holds it until the block takes it. The valid
  // line only drops when a pause follows, so back-to-back beats keep it high.
  task automatic send_beat(input logic [1:0] kind, input logic [15:0] cap);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= cap;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    if (kind == REQ_CAPTURE) end_pending = ~end_pending;
    gap = pause_len(tx_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering beats and waits until every reading has come back. Each
  // event yields exactly one result, so the block is idle afterwards.
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (readings_owed != 0 && waited < 200000);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One measurement: a start edge, some counter wraps and ticks in random
  // order; the end edge repeats the start, steps a little or more, or is random.
  task automatic measure();
    logic [15:0] first_edge;
    logic [15:0] last_edge;
    int          wraps;
    int          ticks;
    int          r;
    first_edge = 16'($urandom);
    r          = $urandom_range(0, 9);
    wraps      = (r < 5) ? 0 : (r < 8) ? 1 : $urandom_range(2, 4);
    ticks      = $urandom_range(0, 3);
    send_beat(REQ_CAPTURE, first_edge);
    while (wraps + ticks > 0) begin
      if (wraps > 0 && (ticks == 0 || $urandom_range(0, 1) == 0)) begin
        send_beat(REQ_OVERFLOW, 16'($urandom));
        wraps--;
      end else begin
        send_beat(REQ_TICK, 16'($urandom));
        ticks--;
      end
    end
    r = $urandom_range(0, 9);
    if (r == 0) last_edge = first_edge;
    else if (r < 4) last_edge = first_edge + 16'($urandom_range(1, 4));
    else if (r < 6) last_edge = first_edge + 16'($urandom_range(5, 4000));
    else last_edge = 16'($urandom);
    send_beat(REQ_CAPTURE, last_edge);
  endtask

  // Receiver. Either ready every cycle, or ready with random stalls, or one long
  // stall while the sender keeps offering beats.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat (pause_len(1'b1) + 1) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] hz;
    logic [31:0] thr;
    logic [31:0] hold;
    int          goal;

    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    long_hold   = 1'b0;
    beats_sent  = 0;
    end_pending = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_CAPTURE;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CLOCK_HZ;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed events at the register values after reset.
    send_beat(REQ_UNUSED, 16'hFFFF);    // ignored kind while idle
    send_beat(REQ_TICK, 16'h0000);
    send_beat(REQ_CAPTURE, 16'h0000);   // start edge
    send_beat(REQ_CAPTURE, 16'hFFFF);   // longest period without a wrap
    send_beat(REQ_OVERFLOW, 16'hFFFF);  // wrap while waiting for a start edge
    send_beat(REQ_CAPTURE, 16'hFFFF);   // start edge clears the wrap count
    send_beat(REQ_OVERFLOW, 16'h0000);
    send_beat(REQ_CAPTURE, 16'h0000);   // period of one: the highest frequency
    send_beat(REQ_CAPTURE, 16'h1234);
    send_beat(REQ_CAPTURE, 16'h1234);   // zero period, no division
    send_beat(REQ_CAPTURE, 16'h0064);
    send_beat(REQ_CAPTURE, 16'h0032);   // end before start wraps: zero quotient
    send_beat(REQ_CAPTURE, 16'h8000);
    send_beat(REQ_UNUSED, 16'h5555);    // ignored kind while waiting for the end
    send_beat(REQ_OVERFLOW, 16'hAAAA);
    send_beat(REQ_TICK, 16'h5555);
    send_beat(REQ_CAPTURE, 16'h7FFF);   // period spans a counter wrap
    settle();

    // Slowest clock with the widest threshold: only a period of one gives a
    // sample, and with no hold-off the touch flag toggles on it.
    write_reg(CFG_CLOCK_HZ, 32'd1);
    write_reg(CFG_THRESHOLD, 32'h03FF_FFFF);
    write_reg(CFG_HOLDOFF, 32'd0);
    send_beat(REQ_CAPTURE, 16'h0010);
    send_beat(REQ_CAPTURE, 16'h0011);
    send_beat(REQ_TICK, 16'h0000);
    send_beat(REQ_CAPTURE, 16'h0000);
    send_beat(REQ_CAPTURE, 16'h0002);
    settle();

    // Random phases, each with its own register setting and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin hz = 32'd64_000_000; thr = 32'd20_000;     hold = 32'd3;     end
        1: begin hz = 32'hFFFF_FFFF;  thr = 32'h03FF_FFFF;  hold = 32'd0;     end
        2: begin hz = 32'd1;          thr = 32'd1;          hold = 32'd0;     end
        3: begin
          hz   = $urandom_range(1000, 100_000_000);
          thr  = {6'($urandom), 26'(hz / $urandom_range(2000, 60000))};
          hold = {16'($urandom), 16'($urandom_range(0, 4))};
        end
        4: begin hz = 32'd64_000_000; thr = 32'd0;          hold = 32'd0;     end
        5: begin hz = 32'd64_000_000; thr = 32'd30_000;     hold = 32'd65534; end
        6: begin hz = 32'd1_000_000;  thr = 32'(1000 + $urandom_range(0, 500));
                  hold = 32'd1; end
        default: begin
          hz   = $urandom;
          thr  = $urandom;
          hold = {16'($urandom), 16'($urandom_range(0, 8))};
        end
      endcase
      write_reg(CFG_CLOCK_HZ, hz);
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_HOLDOFF, hold);
      if (ph == 7) write_reg(CFG_UNUSED, $urandom);
      tx_gaps   = ph[0];
      rx_stalls = ph[1];
      goal      = beats_sent + 80;
      if (ph == 3) begin
        // Back-to-back beats against a stalled receiver fill the block.
        long_hold = 1'b1;
        tx_gaps   = 1'b0;
        repeat (4) measure();
        tx_gaps   = 1'b1;
      end
      while (beats_sent < goal) begin
        if ($urandom_range(0, 4) == 0)
          send_beat(($urandom_range(0, 7) == 0) ? REQ_CAPTURE : 2'($urandom_range(1, 3)),
                    16'($urandom));
        else
          measure();
      end
      settle();
    end

    // Closing run: the window is refilled with small samples so that the sum
    // stays under the widest threshold, then a measurement over many counter
    // wraps and ticks ends with a long final period. The ticks pass the
    // hold-off, so that sample must toggle the flag.
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(CFG_CLOCK_HZ, 32'd64_000_000);
    write_reg(CFG_THRESHOLD, 32'h03FF_FFFF);
    write_reg(CFG_HOLDOFF, 32'd16);
    if (end_pending) send_beat(REQ_CAPTURE, 16'($urandom));
    repeat (WINDOW) begin
      send_beat(REQ_CAPTURE, 16'h0000);
      send_beat(REQ_OVERFLOW, 16'($urandom));
      send_beat(REQ_CAPTURE, 16'h0000);
    end
    send_beat(REQ_CAPTURE, 16'h0100);
    repeat (20) begin
      send_beat(REQ_OVERFLOW, 16'($urandom));
      send_beat(REQ_TICK, 16'($urandom));
    end
    send_beat(REQ_CAPTURE, 16'h0105);
    settle();

    // Let any stray result surface before the verdict.
    repeat (50) @(posedge clk);
    if (mismatches == 0 && readings_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tfc_pkg.sv
hdl/tfc_div.sv
hdl/touch_frequency_counter_unit.sv
verif/touch_frequency_counter_checker.sv
verif/touch_frequency_counter_unit_tb.sv
